FILE: rtl/jbec_pkg.sv
package jbec_pkg;

  localparam int COEF_W      = 11;
  localparam int VAL_W       = COEF_W + 1;  // DC difference needs one more bit
  localparam int SIZE_W      = 4;
  localparam int POS_W       = 6;
  localparam int RUN_W       = 6;
  localparam int CODE_BITS_W = 27;
  localparam int CODE_LEN_W  = 5;
  localparam int DC_CODE_W   = 9;
  localparam int DC_LEN_W    = 4;
  localparam int AC_CODE_W   = 16;
  localparam int AC_ENTRY_W  = AC_CODE_W + CODE_LEN_W;

  localparam logic [POS_W-1:0] LAST_POS = '1;

  // run/size symbol with a fixed meaning
  localparam logic [7:0] SYM_ZRL = 8'hF0;

  // command queue between classifier and code emitter
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    KIND_DC,
    KIND_AC
  } cmd_kind_t;

  // One queued command; an EOB is an AC command of run 0, size 0.
  typedef struct packed {
    cmd_kind_t         kind;
    logic [SIZE_W-1:0] size;
    logic [COEF_W-1:0] vli;
    logic [3:0]        run;
    logic [1:0]        zrl_count;
    logic              eob;
  } jbec_cmd_t;

  localparam logic [DC_CODE_W-1:0] DC_CODE [12] = '{
    9'h000, 9'h002, 9'h003, 9'h004, 9'h005, 9'h006,
    9'h00E, 9'h01E, 9'h03E, 9'h07E, 9'h0FE, 9'h1FE
  };
  localparam logic [DC_LEN_W-1:0] DC_LEN [12] = '{
    4'd2, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9
  };

  // Annex K luminance AC: code counts per length and symbols in code order
  localparam logic [7:0] AC_COUNT [16] = '{
    8'd0, 8'd2, 8'd1, 8'd3, 8'd3, 8'd2, 8'd4, 8'd3,
    8'd5, 8'd5, 8'd4, 8'd4, 8'd0, 8'd0, 8'd1, 8'h7d
  };
  localparam logic [7:0] AC_SYMBOL [162] = '{
    8'h01, 8'h02, 8'h03, 8'h00, 8'h04, 8'h11, 8'h05, 8'h12,
    8'h21, 8'h31, 8'h41, 8'h06, 8'h13, 8'h51, 8'h61, 8'h07,
    8'h22, 8'h71, 8'h14, 8'h32, 8'h81, 8'h91, 8'ha1, 8'h08,
    8'h23, 8'h42, 8'hb1, 8'hc1, 8'h15, 8'h52, 8'hd1, 8'hf0,
    8'h24, 8'h33, 8'h62, 8'h72, 8'h82, 8'h09, 8'h0a, 8'h16,
    8'h17, 8'h18, 8'h19, 8'h1a, 8'h25, 8'h26, 8'h27, 8'h28,
    8'h29, 8'h2a, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
    8'h3a, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49,
    8'h4a, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59,
    8'h5a, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69,
    8'h6a, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78, 8'h79,
    8'h7a, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89,
    8'h8a, 8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98,
    8'h99, 8'h9a, 8'ha2, 8'ha3, 8'ha4, 8'ha5, 8'ha6, 8'ha7,
    8'ha8, 8'ha9, 8'haa, 8'hb2, 8'hb3, 8'hb4, 8'hb5, 8'hb6,
    8'hb7, 8'hb8, 8'hb9, 8'hba, 8'hc2, 8'hc3, 8'hc4, 8'hc5,
    8'hc6, 8'hc7, 8'hc8, 8'hc9, 8'hca, 8'hd2, 8'hd3, 8'hd4,
    8'hd5, 8'hd6, 8'hd7, 8'hd8, 8'hd9, 8'hda, 8'he1, 8'he2,
    8'he3, 8'he4, 8'he5, 8'he6, 8'he7, 8'he8, 8'he9, 8'hea,
    8'hf1, 8'hf2, 8'hf3, 8'hf4, 8'hf5, 8'hf6, 8'hf7, 8'hf8,
    8'hf9, 8'hfa
  };

  // symbol -> {code, length}, built at elaboration from the canonical lists
  typedef logic [255:0][AC_ENTRY_W-1:0] ac_table_t;

  function automatic ac_table_t build_ac_table();
    ac_table_t t;
    int        code;
    int        k;
    for (int e = 0; e < 256; e++) begin
      t[e] = {AC_CODE_W'(0), CODE_LEN_W'(1)};
    end
    code = 0;
    k    = 0;
    for (int l = 0; l < 16; l++) begin
      for (int i = 0; i < int'(AC_COUNT[l]); i++) begin
        t[AC_SYMBOL[k]] = {code[AC_CODE_W-1:0], CODE_LEN_W'(l + 1)};
        code++;
        k++;
      end
      code = code << 1;
    end
    return t;
  endfunction

  localparam ac_table_t AC_TABLE = build_ac_table();

endpackage

FILE: rtl/jbec_front.sv
module jbec_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [jbec_pkg::COEF_W-1:0] coefficient,
  input  logic [jbec_pkg::COEF_W-1:0] previous_dc,
  input  logic                       queue_full,
  output logic                       push,
  output jbec_pkg::jbec_cmd_t        cmd
);

  logic [jbec_pkg::POS_W-1:0]  position;
  logic [jbec_pkg::RUN_W-1:0]  zero_run;
  logic                        accept;
  logic                        is_dc;
  logic                        is_zero;
  logic                        is_last;
  logic [jbec_pkg::VAL_W-1:0]  coef_ext;
  logic [jbec_pkg::VAL_W-1:0]  diff;
  logic [jbec_pkg::VAL_W-1:0]  ac_val;
  logic [jbec_pkg::VAL_W-1:0]  val;
  logic [jbec_pkg::VAL_W-1:0]  mag;
  logic [jbec_pkg::VAL_W-1:0]  vli_word;
  logic [jbec_pkg::VAL_W-1:0]  mask_wide;
  logic [jbec_pkg::SIZE_W-1:0] size;

  assign s_tready = !queue_full;
  assign accept   = s_tvalid && s_tready;
  assign is_dc    = (position == '0);
  assign is_zero  = (coefficient == '0);
  assign is_last  = (position == jbec_pkg::LAST_POS);

  assign coef_ext = {coefficient[jbec_pkg::COEF_W-1], coefficient};
  assign diff     = coef_ext - {previous_dc[jbec_pkg::COEF_W-1], previous_dc};
  // -1024 has no AC size category; clamp to -1023
  assign ac_val   = (coefficient == {1'b1, {(jbec_pkg::COEF_W-1){1'b0}}})
                    ? coef_ext + jbec_pkg::VAL_W'(1) : coef_ext;
  assign val      = is_dc ? diff : ac_val;
  assign mag      = val[jbec_pkg::VAL_W-1] ? (jbec_pkg::VAL_W'(0) - val) : val;

  always_comb begin
    size = '0;
    for (int b = 0; b < jbec_pkg::COEF_W; b++) begin
      if (mag[b]) size = jbec_pkg::SIZE_W'(b + 1);
    end
  end

  // negative values go out as value minus one, low size bits
  assign vli_word  = val[jbec_pkg::VAL_W-1] ? (val - jbec_pkg::VAL_W'(1)) : val;
  assign mask_wide = (jbec_pkg::VAL_W'(1) << size) - jbec_pkg::VAL_W'(1);

  always_comb begin
    cmd.kind      = is_dc ? jbec_pkg::KIND_DC : jbec_pkg::KIND_AC;
    cmd.size      = size;
    cmd.vli       = vli_word[jbec_pkg::COEF_W-1:0] & mask_wide[jbec_pkg::COEF_W-1:0];
    cmd.run       = (is_dc || is_zero) ? 4'd0 : zero_run[3:0];
    cmd.zrl_count = (is_dc || is_zero) ? 2'd0 : zero_run[5:4];
    cmd.eob       = is_last;
  end

  // zero ACs before the last position only lengthen the run
  assign push = accept && (is_dc || !is_zero || is_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      zero_run <= '0;
    end else if (accept) begin
      position <= position + 1'b1;
      if (is_dc || !is_zero || is_last) begin
        zero_run <= '0;
      end else begin
        zero_run <= zero_run + 1'b1;
      end
    end
  end

  a_block_wrap: assert property (@(posedge clk) disable iff (rst)
    (accept && is_last) |=> (position == '0 && zero_run == '0))
    else $error("block end did not restart position and run");

  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    is_dc ? (zero_run == '0) : (zero_run < position))
    else $error("zero run longer than coefficients seen");

endmodule

FILE: rtl/jbec_queue.sv
module jbec_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  jbec_pkg::jbec_cmd_t push_data,
  input  logic                pop,
  output logic                full,
  output logic                q_valid,
  output jbec_pkg::jbec_cmd_t head
);

  jbec_pkg::jbec_cmd_t              mem [jbec_pkg::QUEUE_DEPTH];
  logic [jbec_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [jbec_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [jbec_pkg::QUEUE_CNT_W-1:0] count;

  assign full    = (count == jbec_pkg::QUEUE_CNT_W'(jbec_pkg::QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !q_valid))
    else $error("pop from empty queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= jbec_pkg::QUEUE_CNT_W'(jbec_pkg::QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

FILE: rtl/jbec_back.sv
module jbec_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  jbec_pkg::jbec_cmd_t head,
  output logic                pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [31:0]         m_tdata,   // code_bits[26:0], code_length[31:27]
  output logic                m_tuser,   // last_of_item
  output logic                m_tlast    // end_of_block
);

  logic [1:0]                          zrl_sent;
  logic                                load;
  logic                                zrl_phase;
  logic [7:0]                          sym;
  logic [jbec_pkg::AC_ENTRY_W-1:0]     ac_entry;
  logic [jbec_pkg::AC_CODE_W-1:0]      ac_code;
  logic [jbec_pkg::CODE_LEN_W-1:0]     ac_len;
  logic [jbec_pkg::CODE_BITS_W-1:0]    bits;
  logic [jbec_pkg::CODE_LEN_W-1:0]     len;

  assign load      = !m_tvalid || m_tready;
  assign zrl_phase = (head.kind == jbec_pkg::KIND_AC) && (zrl_sent != head.zrl_count);
  assign pop       = q_valid && load && !zrl_phase;

  assign sym      = zrl_phase ? jbec_pkg::SYM_ZRL : {head.run, head.size};
  assign ac_entry = jbec_pkg::AC_TABLE[sym];
  assign ac_code  = ac_entry[jbec_pkg::AC_ENTRY_W-1:jbec_pkg::CODE_LEN_W];
  assign ac_len   = ac_entry[jbec_pkg::CODE_LEN_W-1:0];

  always_comb begin
    if (zrl_phase) begin
      bits = jbec_pkg::CODE_BITS_W'(ac_code);
      len  = ac_len;
    end else if (head.kind == jbec_pkg::KIND_DC) begin
      bits = (jbec_pkg::CODE_BITS_W'(jbec_pkg::DC_CODE[head.size]) << head.size)
             | jbec_pkg::CODE_BITS_W'(head.vli);
      len  = jbec_pkg::CODE_LEN_W'(jbec_pkg::DC_LEN[head.size])
             + jbec_pkg::CODE_LEN_W'(head.size);
    end else begin
      bits = (jbec_pkg::CODE_BITS_W'(ac_code) << head.size)
             | jbec_pkg::CODE_BITS_W'(head.vli);
      len  = ac_len + jbec_pkg::CODE_LEN_W'(head.size);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      zrl_sent <= '0;
    end else if (load) begin
      m_tvalid <= q_valid;
      if (q_valid) zrl_sent <= zrl_phase ? zrl_sent + 1'b1 : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && q_valid) begin
      m_tdata <= {len, bits};
      m_tuser <= !zrl_phase;
      m_tlast <= !zrl_phase && head.eob;
    end
  end

  a_idle_zrl_clear: assert property (@(posedge clk) disable iff (rst)
    !q_valid |-> (zrl_sent == '0))
    else $error("ZRL count left over with empty queue");

  a_eob_is_final: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> m_tuser)
    else $error("end of block on a non-final result");

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[31:27] != '0))
    else $error("result with zero code length");

endmodule

FILE: rtl/jpeg_block_entropy_coder.sv
// channel  dir  tdata                                      tuser         tlast
// s_*      in   [10:0] coefficient, [21:11] previous_dc     -             -
// m_*      out  [26:0] code_bits, [31:27] code_length      last_of_item  end_of_block
//
// Input takes one coefficient per cycle; ready drops only when the 4-entry command
// queue is full. Each nonzero AC, DC and block-closing EOB becomes one queued command.
// Output gives one result per cycle while the sink is ready: 1 for most commands,
// 1 + run/16 (up to 4) when ZRLs precede an AC code; the emitter limits the rate.
// An accepted command is written into the queue, then into the output register.
// Synchronous reset clears position, zero run, queue, ZRL count and output valid.
module jpeg_block_entropy_coder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // coefficient[10:0], previous_dc[21:11], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // code_bits[26:0], code_length[31:27]
  output logic        m_tuser,   // last_of_item
  output logic        m_tlast    // end_of_block
);

  jbec_pkg::jbec_cmd_t push_cmd;
  jbec_pkg::jbec_cmd_t head;
  logic                push;
  logic                pop;
  logic                full;
  logic                q_valid;

  // classify: DC difference, AC size/run, EOB at a trailing run
  jbec_front u_front (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .coefficient (s_tdata[10:0]),
    .previous_dc (s_tdata[21:11]),
    .queue_full  (full),
    .push        (push),
    .cmd         (push_cmd)
  );

  // absorbs the extra output cycles of long zero runs
  jbec_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .pop       (pop),
    .full      (full),
    .q_valid   (q_valid),
    .head      (head)
  );

  // Huffman lookup, ZRL expansion, output register
  jbec_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

FILE: tb/jpeg_block_entropy_coder_tb.sv
module jpeg_block_entropy_coder_tb;

  localparam int WATCHDOG_CYCLES = 1000;  // cycles without any transfer before giving up
  localparam int HOLD_OFF_CYCLES = 80;    // long sink hold-off, well past queue depth
  localparam int DRAIN_CYCLES    = 20;    // quiet time after the last code, > latency
  localparam logic [7:0] SYM_EOB = 8'h00;

  // Annex K luminance DC table, indexed by size category
  localparam logic [8:0] DC_HUFF [12] = '{
    9'h000, 9'h002, 9'h003, 9'h004, 9'h005, 9'h006,
    9'h00E, 9'h01E, 9'h03E, 9'h07E, 9'h0FE, 9'h1FE
  };
  localparam int DC_HUFF_LEN [12] = '{2, 3, 3, 3, 3, 3, 4, 5, 6, 7, 8, 9};

  // Annex K luminance AC table as canonical lists: codes per length, symbols in order
  localparam int AC_PER_LEN [16] = '{0, 2, 1, 3, 3, 2, 4, 3, 5, 5, 4, 4, 0, 0, 1, 125};
  localparam logic [7:0] AC_SYMS [162] = '{
    8'h01, 8'h02, 8'h03, 8'h00, 8'h04, 8'h11, 8'h05, 8'h12,
    8'h21, 8'h31, 8'h41, 8'h06, 8'h13, 8'h51, 8'h61, 8'h07,
    8'h22, 8'h71, 8'h14, 8'h32, 8'h81, 8'h91, 8'ha1, 8'h08,
    8'h23, 8'h42, 8'hb1, 8'hc1, 8'h15, 8'h52, 8'hd1, 8'hf0,
    8'h24, 8'h33, 8'h62, 8'h72, 8'h82, 8'h09, 8'h0a, 8'h16,
    8'h17, 8'h18, 8'h19, 8'h1a, 8'h25, 8'h26, 8'h27, 8'h28,
    8'h29, 8'h2a, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
    8'h3a, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49,
    8'h4a, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59,
    8'h5a, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69,
    8'h6a, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78, 8'h79,
    8'h7a, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89,
    8'h8a, 8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98,
    8'h99, 8'h9a, 8'ha2, 8'ha3, 8'ha4, 8'ha5, 8'ha6, 8'ha7,
    8'ha8, 8'ha9, 8'haa, 8'hb2, 8'hb3, 8'hb4, 8'hb5, 8'hb6,
    8'hb7, 8'hb8, 8'hb9, 8'hba, 8'hc2, 8'hc3, 8'hc4, 8'hc5,
    8'hc6, 8'hc7, 8'hc8, 8'hc9, 8'hca, 8'hd2, 8'hd3, 8'hd4,
    8'hd5, 8'hd6, 8'hd7, 8'hd8, 8'hd9, 8'hda, 8'he1, 8'he2,
    8'he3, 8'he4, 8'he5, 8'he6, 8'he7, 8'he8, 8'he9, 8'hea,
    8'hf1, 8'hf2, 8'hf3, 8'hf4, 8'hf5, 8'hf6, 8'hf7, 8'hf8,
    8'hf9, 8'hfa
  };

  // one emitted code word as it appears on the output stream
  typedef struct packed {
    logic [jbec_pkg::CODE_BITS_W-1:0] bits;
    logic [jbec_pkg::CODE_LEN_W-1:0]  len;
    logic                             last;  // last code of its item
    logic                             eob;   // last code of the block
  } code_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // coefficient[10:0], previous_dc[21:11], zero pad
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;   // code_bits[26:0], code_length[31:27]
  logic        m_tuser;   // last_of_item
  logic        m_tlast;   // end_of_block

  // coder state as the predictor tracks it
  logic [jbec_pkg::POS_W-1:0] blk_pos = '0;
  logic [jbec_pkg::RUN_W-1:0] run_len = '0;

  code_t code_fifo [$];   // codes predicted but not yet seen
  code_t got_code;
  code_t want_code;
  int    block_ac [64];   // AC values of the next block; cleared as they are sent

  int  errors        = 0;
  int  coefs_sent    = 0;
  int  blocks_sent   = 0;
  int  codes_checked = 0;
  int  zrl_codes     = 0;
  int  eob_codes     = 0;
  int  idle_cycles   = 0;
  int  sink_wait     = 0;
  int  hold_req      = 0;  // bumped by the tests
  int  hold_done     = 0;  // owned by the sink process
  bit  sender_idles  = 1'b1;
  bit  sink_idles    = 1'b1;

  jpeg_block_entropy_coder i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // size category: bit count of the magnitude
  function automatic int vli_size(input int v);
    int m;
    int n;
    m = (v < 0) ? -v : v;
    n = 0;
    while (m != 0) begin
      n++;
      m = m >> 1;
    end
    return n;
  endfunction

  // negative values go out as v - 1, low sz bits
  function automatic int vli_bits(input int v, input int sz);
    int w;
    w = (v < 0) ? v - 1 : v;
    return w & ((1 << sz) - 1);
  endfunction

  // walk the canonical lists to find the code of a run/size symbol
  function automatic void ac_huff(input logic [7:0] sym, output int code, output int len);
    int c;
    int k;
    c    = 0;
    k    = 0;
    code = 0;
    len  = 1;
    for (int l = 0; l < 16; l++) begin
      for (int i = 0; i < AC_PER_LEN[l]; i++) begin
        if (AC_SYMS[k] == sym) begin
          code = c;
          len  = l + 1;
          return;
        end
        c++;
        k++;
      end
      c = c << 1;
    end
  endfunction

  // codes one coefficient and queues the code words it should produce
  function automatic void predict_codes(input logic signed [10:0] coef,
                                        input logic signed [10:0] prev_dc);
    int    bits [4];
    int    lens [4];
    int    n;
    int    value;
    int    run;
    int    sz;
    int    hc;
    int    hl;
    code_t c;
    n = 0;
    if (blk_pos == '0) begin
      // DC: difference to the previous block, up to size 11
      value   = int'(coef) - int'(prev_dc);
      sz      = vli_size(value);
      bits[0] = (int'(DC_HUFF[sz]) << sz) | vli_bits(value, sz);
      lens[0] = DC_HUFF_LEN[sz] + sz;
      n       = 1;
      run_len = '0;
    end else if (coef == 0) begin
      run_len = run_len + 1'b1;
      if (blk_pos == jbec_pkg::LAST_POS) begin
        ac_huff(SYM_EOB, hc, hl);
        bits[0] = hc;
        lens[0] = hl;
        n       = 1;
        eob_codes++;
      end
    end else begin
      // -1024 has no AC size category; it is clamped to -1023
      value = (coef < -1023) ? -1023 : int'(coef);
      run   = int'(run_len);
      while (run > 15) begin
        ac_huff(jbec_pkg::SYM_ZRL, hc, hl);
        bits[n] = hc;
        lens[n] = hl;
        n++;
        run -= 16;
        zrl_codes++;
      end
      sz = vli_size(value);
      ac_huff(8'((run << 4) | sz), hc, hl);
      bits[n] = (hc << sz) | vli_bits(value, sz);
      lens[n] = hl + sz;
      n++;
      run_len = '0;
    end
    for (int i = 0; i < n; i++) begin
      c.bits = jbec_pkg::CODE_BITS_W'(bits[i]);
      c.len  = jbec_pkg::CODE_LEN_W'(lens[i]);
      c.last = (i == n - 1);
      c.eob  = (i == n - 1) && (blk_pos == jbec_pkg::LAST_POS);
      code_fifo.push_back(c);
    end
    blk_pos = blk_pos + 1'b1;
    if (blk_pos == '0) begin
      run_len = '0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Source side
  // ---------------------------------------------------------------------------

  // offers one coefficient item, optionally after an idle burst
  task automatic send_coef(input int coef, input int prev_dc);
    logic signed [10:0] c;
    logic signed [10:0] p;
    c = coef[10:0];
    p = prev_dc[10:0];
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, p, c};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_codes(c, p);
    coefs_sent++;
  endtask

  // sends positions first..last of a block: DC at 0, block_ac elsewhere;
  // previous_dc is noise on AC items
  task automatic send_span(input int first, input int last, input int dc,
                           input int prev_dc);
    for (int pos = first; pos <= last; pos++) begin
      if (pos == 0) begin
        send_coef(dc, prev_dc);
      end else begin
        send_coef(block_ac[pos], $urandom_range(0, 2047) - 1024);
        block_ac[pos] = 0;
      end
    end
    if (last == 63) begin
      blocks_sent++;
    end
  endtask

  task automatic send_block(input int dc, input int prev_dc);
    send_span(0, 63, dc, prev_dc);
  endtask

  // source goes quiet until every predicted code has come out
  task automatic wait_codes_drained();
    s_tvalid <= 1'b0;
    while (code_fifo.size() != 0) @(posedge clk);
  endtask

  // mostly small magnitudes of every size, now and then the clamped -1024
  function automatic int rand_ac();
    int sz;
    int mag;
    if ($urandom_range(0, 19) == 0) begin
      return -1024;
    end
    sz  = $urandom_range(1, 10);
    mag = $urandom_range(1 << (sz - 1), (1 << sz) - 1);
    return ($urandom_range(0, 1) != 0) ? -mag : mag;
  endfunction

  function automatic void fill_random(input int first, input int last, input int nonzero_pct);
    for (int pos = first; pos <= last; pos++) begin
      if ($urandom_range(0, 99) < nonzero_pct) begin
        block_ac[pos] = rand_ac();
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // largest DC step, AC range ends, clamped -1024, a 3-ZRL chain,
  // nonzero last coefficient closing the block without EOB
  task automatic test_extreme_values();
    block_ac[1]  = 1023;
    block_ac[2]  = -1024;
    block_ac[3]  = -1;
    block_ac[4]  = 1;
    block_ac[55] = 5;     // run of 50: three ZRL then run 2
    block_ac[63] = -7;
    send_block(1023, -1024);
  endtask

  // zero DC difference; run 15 needs no ZRL, run 16 needs exactly one;
  // trailing zeros end in EOB
  task automatic test_zero_runs();
    block_ac[16] = 2;
    block_ac[33] = -3;
    send_block(300, 300);
  endtask

  // most negative DC step, then dense ACs while the sink holds off long
  // enough to fill the command queue
  task automatic test_backpressure();
    hold_req <= hold_req + 1;
    fill_random(1, 15, 85);
    send_span(0, 15, -1024, 1023);
  endtask

  // sparse middle of the block gives long runs and ZRL chains
  task automatic test_sparse_blocks();
    fill_random(16, 47, 6);
    send_span(16, 47, 0, 0);
    wait_codes_drained();
  endtask

  // back-to-back traffic with no idling on either side to the block end
  task automatic test_full_rate();
    sender_idles = 1'b0;
    sink_idles   = 1'b0;
    fill_random(48, 63, 40);
    send_span(48, 63, 0, 0);
  endtask

  // ---------------------------------------------------------------------------
  // Sink side: check accepted codes, then pick next tready
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_code.bits = m_tdata[jbec_pkg::CODE_BITS_W-1:0];
      got_code.len  = m_tdata[jbec_pkg::CODE_BITS_W+jbec_pkg::CODE_LEN_W-1:
                              jbec_pkg::CODE_BITS_W];
      got_code.last = m_tuser;
      got_code.eob  = m_tlast;
      if (code_fifo.size() == 0) begin
        errors++;
        $display("%0t: unexpected code bits=%h len=%0d last=%b eob=%b", $time,
                 got_code.bits, got_code.len, got_code.last, got_code.eob);
      end else begin
        want_code = code_fifo.pop_front();
        codes_checked++;
        if (got_code !== want_code) begin
          errors++;
          $display("%0t: code mismatch expected bits=%h len=%0d last=%b eob=%b", $time,
                   want_code.bits, want_code.len, want_code.last, want_code.eob);
          $display("%0t:               actual   bits=%h len=%0d last=%b eob=%b", $time,
                   got_code.bits, got_code.len, got_code.last, got_code.eob);
        end
      end
    end

    if (hold_req != hold_done) begin
      hold_done = hold_req;
      sink_wait = HOLD_OFF_CYCLES - 1;
      m_tready <= 1'b0;
    end else if (sink_wait > 0) begin
      sink_wait--;
      m_tready <= 1'b0;
    end else if (sink_idles && $urandom_range(0, 5) == 0) begin
      sink_wait = $urandom_range(0, 4);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // watchdog: give up when neither side moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("%0t: no transfer for %0d cycles, %0d codes outstanding", $time,
                 idle_cycles, code_fifo.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < 64; i++) begin
      block_ac[i] = 0;
    end
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_extreme_values();
    test_zero_runs();
    wait_codes_drained();
    test_backpressure();
    test_sparse_blocks();
    test_full_rate();

    wait_codes_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Coded %0d blocks (%0d coefficients) under random and long back-pressure;",
             blocks_sent, coefs_sent);
    $display("checked %0d code words, %0d of them ZRL and %0d EOB.",
             codes_checked, zrl_codes, eob_codes);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
